/* sv/sem_pkg.sv */
// Shared types and constants of the Sobel edge magnitude core.
package sem_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int MODE_REG_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MODE = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [MODE_REG_W-1:0]   MODE_RESET   = 3'd3;

    localparam logic [MODE_REG_W-1:0] MODE_GREY = 3'd1;
    localparam logic [MODE_REG_W-1:0] MODE_RGB  = 3'd3;
    localparam logic [MODE_REG_W-1:0] MODE_RGBA = 3'd4;

    localparam int LUMA_W = 16;
    localparam int SUM_W  = 18;
    localparam int NUM_W  = 26;
    localparam int RCP_W  = 27;
    localparam int PROD_W = NUM_W + RCP_W;
    localparam int RECIP_SHIFT = 36;

    localparam logic [SUM_W-1:0] COEF_R = 18'd299;
    localparam logic [SUM_W-1:0] COEF_G = 18'd587;
    localparam logic [SUM_W-1:0] COEF_B = 18'd114;
    localparam logic [NUM_W-1:0] GREY_GAIN  = 26'd256000;
    localparam logic [NUM_W-1:0] LUMA_ROUND = 26'd500;
    // ceil(2^36 / 1000): exact quotient for numerators below 2^26
    localparam logic [RCP_W-1:0] LUMA_RECIP = 27'd68719477;

    localparam int GRAD_W = 18;
    localparam int SQ_W   = 2 * GRAD_W;
    localparam int RAD_W  = 30;
    localparam int REM_W  = 17;
    localparam int MAG_W  = 15;
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ROOT_LAST = 4'd14;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LUMA = 7'b0000010,
        ST_WIN  = 7'b0000100,
        ST_SQR  = 7'b0001000,
        ST_SUM  = 7'b0010000,
        ST_ROOT = 7'b0100000,
        ST_OUT  = 7'b1000000
    } sem_state_t;

endpackage

/* sv/sem_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/sobel_edge_magnitude_core.sv */
// Streaming 3x3 Sobel edge magnitude core with line stores in one RAM.
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tdata {blue,green,red}, s_tuser kind
//  m_        out        m_tvalid/m_tready  m_tdata magnitude, m_tlast, m_tuser bad
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wr_data
//
// An item that yields no result goes through accept, RAM read and window update.
// An item with a result then goes through square, sum, the 15-step square root and output.
// Both line stores share one RAM entry per column, read then written back.
// Reset is synchronous on aresetn low; RAM contents are left as they are.
// A held result in the output register stalls the core only at its next result.
module sobel_edge_magnitude_core
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic                   s_tuser,   // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // magnitude [14:0], zero [15]
    output logic                   m_tlast,
    output logic                   m_tuser,   // bad_mode
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CW1 = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 3);

    sem_state_t state_reg, state_next;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [MODE_REG_W-1:0]   mode_reg;

    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic [CW-1:0]  cx_reg;
    logic [RW-1:0]  cy_reg;
    logic [CW1-1:0] wc;
    logic [RW-1:0]  hc;
    logic [CW-1:0]  cx_next;
    logic [RW-1:0]  cy_next;
    logic [RW-1:0]  row_bump;
    logic           mode_ok;
    logic           bad_reg;
    logic           fe_reg;

    logic [SUM_W-1:0]  wsum;
    logic [NUM_W-1:0]  num_next;
    logic [NUM_W-1:0]  num_reg;
    logic [PROD_W-1:0] prod;
    logic [LUMA_W-1:0] v_reg;

    logic [2*LUMA_W-1:0] rd_data;
    logic [LUMA_W-1:0]   up, lo;
    logic [LUMA_W-1:0]   win_reg  [9];
    logic [LUMA_W-1:0]   win_next [9];
    logic [LUMA_W-1:0]   eval     [9];
    logic                col_zero;
    logic                due;
    logic                fe;
    logic [CW1-1:0]      col_inc;

    logic [GRAD_W-1:0] sum_xp, sum_xn, sum_yp, sum_yn;
    logic [GRAD_W-1:0] gxa_reg, gya_reg;
    logic [SQ_W-1:0]   gxs_reg, gys_reg;
    logic [SQ_W:0]     sq_sum;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  root_reg;
    logic [STEP_W-1:0] step_reg;
    logic [REM_W+1:0]  rem_shift;
    logic [REM_W+1:0]  trial;

    logic             m_tvalid_reg;
    logic [MAG_W-1:0] mag_out_reg;
    logic             last_out_reg;
    logic             bad_out_reg;

    logic accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // clamped geometry
    always_comb begin
        if (width_reg == '0) begin
            wc = CW1'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            wc = CW1'(MAX_WIDTH);
        end else begin
            wc = CW1'(width_reg);
        end
        if (height_reg == '0) begin
            hc = RW'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            hc = RW'(MAX_HEIGHT);
        end else begin
            hc = RW'(height_reg);
        end
    end

    always_comb begin
        unique case (mode_reg) inside
            MODE_GREY, MODE_RGB, MODE_RGBA: mode_ok = 1'b1;
            default:                        mode_ok = 1'b0;
        endcase
    end

    // position of the item being accepted
    always_comb begin
        cx_next  = col_reg;
        row_bump = row_reg;
        if (CW1'(col_reg) >= wc) begin
            cx_next  = '0;
            row_bump = row_reg + RW'(1);
        end
        cy_next = (row_bump > hc + RW'(1)) ? '0 : row_bump;
    end

    always_comb begin
        wsum = SUM_W'(s_tdata[7:0]) * COEF_R + SUM_W'(s_tdata[15:8]) * COEF_G
             + SUM_W'(s_tdata[23:16]) * COEF_B;
        if (!mode_ok || s_tuser || (cy_next >= hc)) begin
            num_next = '0;
        end else if (mode_reg == MODE_GREY) begin
            num_next = NUM_W'(s_tdata[7:0]) * GREY_GAIN + LUMA_ROUND;
        end else begin
            num_next = {wsum, 8'h00} + LUMA_ROUND;
        end
    end

    assign prod = PROD_W'(num_reg) * PROD_W'(LUMA_RECIP);

    sem_ram #(
        .WIDTH (2 * LUMA_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_WIN),
        .wr_addr (cx_reg),
        .wr_data ({rd_data[LUMA_W-1:0], v_reg}),
        .rd_en   (accept),
        .rd_addr (cx_next),
        .rd_data (rd_data)
    );

    assign up = (cy_reg >= RW'(2)) ? rd_data[2*LUMA_W-1:LUMA_W] : '0;
    assign lo = (cy_reg >= RW'(1)) ? rd_data[LUMA_W-1:0] : '0;
    assign col_zero = (cx_reg == '0);

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (col_zero) begin
                win_next[3*r]   = '0;
                win_next[3*r+1] = '0;
            end else begin
                win_next[3*r]   = win_reg[3*r+1];
                win_next[3*r+1] = win_reg[3*r+2];
            end
        end
        win_next[2] = up;
        win_next[5] = lo;
        win_next[8] = v_reg;
        for (int i = 0; i < 9; i++) begin
            eval[i] = win_next[i];
        end
        if (col_zero) begin
            for (int r = 0; r < 3; r++) begin
                eval[3*r]   = win_reg[3*r+1];
                eval[3*r+1] = win_reg[3*r+2];
                eval[3*r+2] = '0;
            end
        end
    end

    always_comb begin
        sum_xp = GRAD_W'(eval[2]) + {1'b0, eval[5], 1'b0} + GRAD_W'(eval[8]);
        sum_xn = GRAD_W'(eval[0]) + {1'b0, eval[3], 1'b0} + GRAD_W'(eval[6]);
        sum_yp = GRAD_W'(eval[6]) + {1'b0, eval[7], 1'b0} + GRAD_W'(eval[8]);
        sum_yn = GRAD_W'(eval[0]) + {1'b0, eval[1], 1'b0} + GRAD_W'(eval[2]);
    end

    assign due     = (cy_reg >= RW'(2)) || ((cy_reg == RW'(1)) && !col_zero);
    assign fe      = col_zero && (cy_reg == hc + RW'(1));
    assign col_inc = CW1'(cx_reg) + CW1'(1);
    assign sq_sum  = (SQ_W+1)'(gxs_reg) + (SQ_W+1)'(gys_reg);

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = (REM_W+2)'({root_reg, 2'b01});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LUMA;
            ST_LUMA: state_next = ST_WIN;
            ST_WIN:  state_next = due ? ST_SQR : ST_IDLE;
            ST_SQR:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_ROOT;
            ST_ROOT: if (step_reg == ROOT_LAST) state_next = ST_OUT;
            ST_OUT:  if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            mode_reg     <= MODE_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data[HEIGHT_REG_W-1:0];
                    REG_CHANNEL_MODE: mode_reg   <= cfg_wr_data[MODE_REG_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_WIN) begin
                for (int i = 0; i < 9; i++) begin
                    win_reg[i] <= win_next[i];
                end
                if (fe) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (col_inc >= wc) begin
                    col_reg <= '0;
                    row_reg <= cy_reg + RW'(1);
                end else begin
                    col_reg <= col_inc[CW-1:0];
                    row_reg <= cy_reg;
                end
            end
            if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            num_reg <= num_next;
            bad_reg <= !mode_ok;
        end
        if (state_reg == ST_LUMA) begin
            v_reg <= prod[RECIP_SHIFT +: LUMA_W];
        end
        if (state_reg == ST_WIN) begin
            fe_reg  <= fe;
            gxa_reg <= (sum_xp >= sum_xn) ? sum_xp - sum_xn : sum_xn - sum_xp;
            gya_reg <= (sum_yp >= sum_yn) ? sum_yp - sum_yn : sum_yn - sum_yp;
        end
        if (state_reg == ST_SQR) begin
            gxs_reg <= SQ_W'(gxa_reg) * SQ_W'(gxa_reg);
            gys_reg <= SQ_W'(gya_reg) * SQ_W'(gya_reg);
        end
        if (state_reg == ST_SUM) begin
            rad_reg  <= RAD_W'(sq_sum[SQ_W:8]);
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end
        if (state_reg == ST_ROOT) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            step_reg <= step_reg + STEP_W'(1);
            if (rem_shift >= trial) begin
                rem_reg  <= REM_W'(rem_shift - trial);
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end else begin
                rem_reg  <= REM_W'(rem_shift);
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
        if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready)) begin
            mag_out_reg  <= bad_reg ? '0 : root_reg;
            last_out_reg <= fe_reg;
            bad_out_reg  <= bad_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, mag_out_reg};
    assign m_tlast  = last_out_reg;
    assign m_tuser  = bad_out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT) |-> (step_reg <= ROOT_LAST))
        else $error("square root step count overran");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("nonzero magnitude with unsupported mode");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(col_reg) < 32'(MAX_WIDTH)) && (32'(row_reg) <= 32'(MAX_HEIGHT) + 32'd1))
        else $error("position counter out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WIN) |=> (state_reg == ST_IDLE) || (state_reg == ST_SQR))
        else $error("window update not followed by idle or square stage");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Sobel edge magnitude core, checking every result against a prediction or a typed row.
module tb_top;
    import sem_pkg::*;

    localparam int MAX_W = 2048;
    localparam int MAX_H = 4096;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_ITEMS = 1500;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;
    localparam logic [MODE_REG_W-1:0] MODE_NONE = 3'd0;
    localparam logic [MODE_REG_W-1:0] MODE_TWO  = 3'd2;
    localparam logic [MODE_REG_W-1:0] MODE_ALL  = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             last;
        logic             bad;
    } grad_t;

    typedef struct packed {
        int                    width;
        int                    height;
        logic [MODE_REG_W-1:0] mode;
        logic                  kind;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic                  typed;
        grad_t                 want;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata = '0;      // red [7:0], green [15:8], blue [23:16]
    logic                   s_tuser = 1'b0;    // kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [15:0]            m_tdata;           // magnitude [14:0], zero [15]
    logic                   m_tlast;
    logic                   m_tuser;           // bad_mode
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    logic [WIDTH_REG_W-1:0]  reg_width = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] reg_height = HEIGHT_RESET;
    logic [MODE_REG_W-1:0]   reg_mode = MODE_RESET;
    logic [LUMA_W-1:0]       upper_store [MAX_W];
    logic [LUMA_W-1:0]       lower_store [MAX_W];
    logic [LUMA_W-1:0]       win [9];
    int unsigned             col_pos = 0;
    int unsigned             row_pos = 0;

    grad_t grad_due_q [$];
    int    fail_count = 0;
    int    items_sent = 0;
    int    results_seen = 0;
    int    ends_seen = 0;
    int    bad_seen = 0;
    int    settings_used = 0;
    bit    gaps_off = 1'b0;
    bit    long_hold_req = 1'b0;
    int    hold_left = 0;

    sobel_edge_magnitude_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit grad_predict(input logic kind, input logic [7:0] red,
                                        input logic [7:0] green, input logic [7:0] blue,
                                        output grad_t res);
        int unsigned       w, h, cx, cy, luma, up, lo;
        logic [LUMA_W-1:0] ev [9];
        bit                bad, due, fe;
        longint            gx, gy;
        longint unsigned   sq, root, trial;
        w = reg_width;
        h = reg_height;
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        if (h < 1) h = 1;
        if (h > MAX_H) h = MAX_H;
        bad = !(reg_mode == MODE_GREY || reg_mode == MODE_RGB || reg_mode == MODE_RGBA);
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos > h + 1) row_pos = 0;
        cx = col_pos;
        cy = row_pos;
        luma = 0;
        if (!bad && kind == KIND_PIXEL && cy < h) begin
            if (reg_mode == MODE_GREY) luma = {red, 8'h00};
            else luma = ((299 * red + 587 * green + 114 * blue) * 256 + 500) / 1000;
        end
        up = (cy >= 2) ? upper_store[cx] : 0;
        lo = (cy >= 1) ? lower_store[cx] : 0;
        upper_store[cx] = lower_store[cx];
        lower_store[cx] = luma[LUMA_W-1:0];
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        if (cx == 0) begin
            for (int r = 0; r < 3; r++) begin
                ev[r*3]    = win[r*3];
                ev[r*3+1]  = win[r*3+1];
                ev[r*3+2]  = '0;
                win[r*3]   = '0;
                win[r*3+1] = '0;
            end
        end
        win[2] = up[LUMA_W-1:0];
        win[5] = lo[LUMA_W-1:0];
        win[8] = luma[LUMA_W-1:0];
        if (cx != 0) ev = win;
        due = (cy >= 2) || (cy == 1 && cx >= 1);
        fe = (cx == 0 && cy == h + 1);
        if (fe) begin
            col_pos = 0;
            row_pos = 0;
        end else begin
            col_pos = cx + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = cy + 1;
            end
        end
        gx = longint'(ev[2]) + 2 * longint'(ev[5]) + longint'(ev[8])
           - longint'(ev[0]) - 2 * longint'(ev[3]) - longint'(ev[6]);
        gy = longint'(ev[6]) + 2 * longint'(ev[7]) + longint'(ev[8])
           - longint'(ev[0]) - 2 * longint'(ev[1]) - longint'(ev[2]);
        sq = gx * gx + gy * gy;
        sq = sq >> 8;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq) root = trial;
        end
        res.mag = bad ? '0 : root[MAG_W-1:0];
        res.last = fe;
        res.bad = bad;
        return due;
    endfunction

    function automatic int random_gap();
        int pick;
        if (gaps_off) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pixel_sample();
        if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 40)
            $display("%0t MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic send_item(input logic kind, input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic typed, input grad_t want);
        grad_t predicted;
        int    gap;
        gap = random_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {blue, green, red};
        s_tuser <= kind;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (grad_predict(kind, red, green, blue, predicted))
            grad_due_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (grad_due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wr_data <= value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            REG_IMAGE_WIDTH:  reg_width = value[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: reg_height = value[HEIGHT_REG_W-1:0];
            REG_CHANNEL_MODE: reg_mode = value[MODE_REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int width, input int height,
                                input logic [MODE_REG_W-1:0] mode);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_CHANNEL_MODE, mode);
        settings_used++;
    endtask

    task automatic send_frame(input int width, input int height, input int pause_at);
        int   total;
        logic kind;
        total = width * height + width + 1;
        for (int i = 0; i < total; i++) begin
            if (i == pause_at) settle();
            if (i < width * height) kind = ($urandom_range(0, 15) == 0) ? KIND_FLUSH : KIND_PIXEL;
            else kind = ($urandom_range(0, 7) == 0) ? KIND_PIXEL : KIND_FLUSH;
            send_item(kind, pixel_sample(), pixel_sample(), pixel_sample(), 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin : check_results
        grad_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tlast) ends_seen++;
            if (m_tuser) bad_seen++;
            if (grad_due_q.size() == 0) begin
                report_mismatch("result with none due, magnitude", m_tdata, 0);
            end else begin
                want = grad_due_q.pop_front();
                if (m_tdata !== {1'b0, want.mag}) report_mismatch("magnitude", m_tdata, want.mag);
                if (m_tlast !== want.last) report_mismatch("frame end", m_tlast, want.last);
                if (m_tuser !== want.bad) report_mismatch("bad mode", m_tuser, want.bad);
            end
        end
    end

    initial begin : result_ready
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else begin
                gap = random_gap();
                m_tready <= (gap == 0);
                if (gap > 0) hold_left = gap - 1;
            end
        end
    end

    initial begin : stimulus
        dir_row_t              dir_rows [$];
        int                    cur_w, cur_h, w, h, nframes, phase, random_start, pick;
        logic [MODE_REG_W-1:0] cur_mode, mode;
        for (int i = 0; i < MAX_W; i++) begin
            upper_store[i] = '0;
            lower_store[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        dir_rows = '{
            '{1, 1, MODE_GREY, KIND_PIXEL, 8'hFF, 8'h00, 8'h00, 1'b0, '0},
            '{1, 1, MODE_GREY, KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
            '{1, 1, MODE_GREY, KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, '{15'd0, 1'b1, 1'b0}},
            '{1, 1, MODE_TWO,  KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
            '{1, 1, MODE_TWO,  KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
            '{1, 1, MODE_TWO,  KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, '{15'd0, 1'b1, 1'b1}},
            '{3, 2, MODE_RGB,  KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
            '{3, 2, MODE_RGB,  KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, '0},
            '{3, 2, MODE_RGB,  KIND_PIXEL, 8'hFF, 8'h00, 8'h00, 1'b0, '0},
            '{3, 2, MODE_RGB,  KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
            '{3, 2, MODE_RGB,  KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b0, '0},
            '{3, 2, MODE_RGB,  KIND_PIXEL, 8'h00, 8'h00, 8'hFF, 1'b0, '0},
            '{3, 2, MODE_RGB,  KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
            '{3, 2, MODE_RGB,  KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
            '{3, 2, MODE_RGB,  KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
            '{3, 2, MODE_RGB,  KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
            '{2, 1, MODE_RGBA, KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
            '{2, 1, MODE_RGBA, KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, '0},
            '{2, 1, MODE_RGBA, KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
            '{2, 1, MODE_RGBA, KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
            '{2, 1, MODE_RGBA, KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0}
        };
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        write_reg(REG_SPARE, 'h1FFF);
        cur_w = WIDTH_RESET;
        cur_h = HEIGHT_RESET;
        cur_mode = MODE_RESET;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].width != cur_w || dir_rows[i].height != cur_h ||
                dir_rows[i].mode != cur_mode) begin
                settle();
                cur_w = dir_rows[i].width;
                cur_h = dir_rows[i].height;
                cur_mode = dir_rows[i].mode;
                set_geometry(cur_w, cur_h, cur_mode);
            end
            send_item(dir_rows[i].kind, dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                      dir_rows[i].typed, dir_rows[i].want);
        end

        settle();
        set_geometry(5, 0, MODE_ALL);
        send_frame(5, 1, -1);
        settle();
        set_geometry(0, 2, MODE_NONE);
        send_frame(1, 2, -1);

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            h = $urandom_range(1, 6);
            pick = $urandom_range(0, 9);
            if (pick < 3) mode = MODE_GREY;
            else if (pick < 6) mode = MODE_RGB;
            else if (pick < 8) mode = MODE_RGBA;
            else mode = MODE_REG_W'($urandom_range(0, 7));
            if (phase == 1 || phase == 2) begin
                w = 6 + phase;
                h = 4;
                mode = MODE_RGB;
            end
            settle();
            gaps_off = (phase % 4 == 3);
            set_geometry(w, h, mode);
            if (phase == 1) long_hold_req = 1'b1;
            nframes = $urandom_range(1, 3);
            repeat (nframes) send_frame(w, h, (phase == 2) ? (w * h) / 2 : -1);
            phase++;
        end
        gaps_off = 1'b0;
        settle();

        $display("Ran %0d items through %0d settings (grey, RGB, RGBA, unsupported modes),",
                 items_sent, settings_used);
        $display("frames 1x1 to 12x6 and zero geometry; %0d results, %0d frame ends, %0d flagged.",
                 results_seen, ends_seen, bad_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("Timeout waiting for the core");
        $display("Test completed with failures");
        $finish;
    end

endmodule
